>>> design/stsq_pkg.sv
// Shared types and constants for the serial transmit stuffing queue.
// No dependencies; compile before every other file of the block.
package stsq_pkg;

  // Bytes with a meaning on the line.
  localparam logic [7:0] BYTE_XOFF = 8'd19;
  localparam logic [7:0] BYTE_XON  = 8'd17;
  localparam logic [7:0] BYTE_ESC  = 8'd0;

  // Codes in req_type. The three reserved ones set no flag but may still send.
  typedef enum logic [2:0] {
    REQ_ENQUEUE    = 3'd0,
    REQ_LINE_READY = 3'd1,
    REQ_XOFF       = 3'd2,
    REQ_XON        = 3'd3,
    REQ_PEER_FLOW  = 3'd4,
    REQ_RSVD_5     = 3'd5,
    REQ_RSVD_6     = 3'd6,
    REQ_RSVD_7     = 3'd7
  } req_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_t;

endpackage

>>> design/stsq_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// No dependencies on other files.
interface stsq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       peer_stop;

  modport source (output valid, req_type, data_byte, peer_stop, input ready);
  modport sink   (input valid, req_type, data_byte, peer_stop, output ready);
endinterface

interface stsq_out_if #(
  parameter int LVL_W = 9
);
  logic             valid;
  logic             ready;
  logic [7:0]       tx_byte;
  logic [LVL_W-1:0] queue_level;
  logic             overflow;

  modport source (output valid, tx_byte, queue_level, overflow, input ready);
  modport sink   (input valid, tx_byte, queue_level, overflow, output ready);
endinterface

>>> design/serial_tx_stuffing_queue.sv
// Serial transmit queue with XON/XOFF flow control and escape stuffing.
// A result, if any, is registered in the send state after its event word is accepted.
// No new word is taken until the last has left the send state, which takes the head byte
// from the memory read. A full result register stalls the send state until taken.
// Reset (rst_n, synchronous, active low) empties the queue, frees the line and clears
// all flow-control flags; the queue memory itself is not cleared.
module serial_tx_stuffing_queue #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  stsq_in_if.sink       in_ch,
  stsq_out_if.source    out_ch
);
  import stsq_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LVL_W-1:0]  DEPTH_LVL = LVL_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(QUEUE_DEPTH);

  // Controller state and queue pointers.
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [LVL_W-1:0]    fill_r, fill_nxt;

  // Line and flow-control flags.
  logic line_free_r,    line_free_nxt;
  logic peer_stopped_r, peer_stopped_nxt;
  logic stop_sent_r,    stop_sent_nxt;
  logic stop_pend_r,    stop_pend_nxt;
  logic go_pend_r,      go_pend_nxt;
  logic esc_sent_r,     esc_sent_nxt;

  // Carried from the accept cycle into the send cycle. When the queue was empty
  // and the event enqueued a byte, that byte is the head and is taken from here
  // instead of from the memory, whose read and write hit the same entry.
  logic       dropped_r,  dropped_nxt;
  logic       fwd_r,      fwd_nxt;
  logic [7:0] fwd_data_r, fwd_data_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       tx_byte_r,   tx_byte_nxt;
  logic [LVL_W-1:0] level_r,     level_nxt;
  logic             ovf_r,       ovf_nxt;

  // Queue memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  logic              accept;
  logic [ADDR_W:0]   tail_sum;
  logic [ADDR_W:0]   head_inc;
  logic [ADDR_W-1:0] head_next_pos;
  logic [7:0]        head_byte;
  logic              send;
  logic              emit;
  logic [7:0]        tx_sel;
  logic              pop;

  stsq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // The tail lies fill entries past the head. The fill is below the depth
  // whenever it is used here, so one conditional subtract wraps the ring.
  assign tail_sum  = {1'b0, head_r} + {1'b0, fill_r[ADDR_W-1:0]};
  assign ram_waddr = (tail_sum >= DEPTH_EXT) ? ADDR_W'(tail_sum - DEPTH_EXT)
                                             : tail_sum[ADDR_W-1:0];

  assign head_inc      = {1'b0, head_r} + (ADDR_W + 1)'(1);
  assign head_next_pos = (head_inc == DEPTH_EXT) ? '0 : head_inc[ADDR_W-1:0];

  assign head_byte = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    fill_nxt         = fill_r;
    line_free_nxt    = line_free_r;
    peer_stopped_nxt = peer_stopped_r;
    stop_sent_nxt    = stop_sent_r;
    stop_pend_nxt    = stop_pend_r;
    go_pend_nxt      = go_pend_r;
    esc_sent_nxt     = esc_sent_r;
    dropped_nxt      = dropped_r;
    fwd_nxt          = fwd_r;
    fwd_data_nxt     = fwd_data_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    tx_byte_nxt      = tx_byte_r;
    level_nxt        = level_r;
    ovf_nxt          = ovf_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    send             = 1'b0;
    pop              = 1'b0;
    tx_sel           = BYTE_ESC;
    emit             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // Apply the event word and start the read of the head byte.
        if (accept) begin
          ram_re       = 1'b1;
          dropped_nxt  = 1'b0;
          fwd_nxt      = 1'b0;
          fwd_data_nxt = in_ch.data_byte;
          state_nxt    = ST_SEND;
          case (in_ch.req_type)
            REQ_ENQUEUE: begin
              if (fill_r == DEPTH_LVL) begin
                dropped_nxt = 1'b1;
              end else begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + LVL_W'(1);
                fwd_nxt  = (fill_r == '0);
              end
            end
            REQ_LINE_READY: line_free_nxt = 1'b1;
            REQ_XOFF: begin
              if (!stop_sent_r) begin
                stop_pend_nxt = 1'b1;
              end
            end
            REQ_XON: begin
              if (stop_sent_r) begin
                go_pend_nxt = 1'b1;
              end
            end
            REQ_PEER_FLOW: peer_stopped_nxt = in_ch.peer_stop;
            default: ;
          endcase
        end
      end

      ST_SEND: begin
        // Flow bytes first and regardless of the peer; data only when allowed.
        if (line_free_r) begin
          if (stop_pend_r) begin
            send   = 1'b1;
            tx_sel = BYTE_XOFF;
          end else if (go_pend_r) begin
            send   = 1'b1;
            tx_sel = BYTE_XON;
          end else if (!peer_stopped_r && fill_r != '0) begin
            send = 1'b1;
            if ((head_byte == BYTE_ESC || head_byte == BYTE_XON ||
                 head_byte == BYTE_XOFF) && !esc_sent_r) begin
              tx_sel = BYTE_ESC;
            end else begin
              tx_sel = head_byte;
              pop    = 1'b1;
            end
          end
        end
        emit = send || dropped_r;

        // Hold everything while a result is due and the result register is full.
        if (!(emit && out_valid_r && !out_ch.ready)) begin
          state_nxt = ST_IDLE;
          if (send) begin
            line_free_nxt = 1'b0;
            if (stop_pend_r) begin
              stop_sent_nxt = 1'b1;
              stop_pend_nxt = 1'b0;
            end else if (go_pend_r) begin
              stop_sent_nxt = 1'b0;
              go_pend_nxt   = 1'b0;
            end else if (pop) begin
              esc_sent_nxt = 1'b0;
              head_nxt     = head_next_pos;
              fill_nxt     = fill_r - LVL_W'(1);
            end else begin
              esc_sent_nxt = 1'b1;
            end
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
            tx_byte_nxt   = send ? tx_sel : BYTE_ESC;
            level_nxt     = pop ? fill_r - LVL_W'(1) : fill_r;
            ovf_nxt       = dropped_r;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      head_r         <= '0;
      fill_r         <= '0;
      line_free_r    <= 1'b1;
      peer_stopped_r <= 1'b0;
      stop_sent_r    <= 1'b0;
      stop_pend_r    <= 1'b0;
      go_pend_r      <= 1'b0;
      esc_sent_r     <= 1'b0;
      dropped_r      <= 1'b0;
      fwd_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      fill_r         <= fill_nxt;
      line_free_r    <= line_free_nxt;
      peer_stopped_r <= peer_stopped_nxt;
      stop_sent_r    <= stop_sent_nxt;
      stop_pend_r    <= stop_pend_nxt;
      go_pend_r      <= go_pend_nxt;
      esc_sent_r     <= esc_sent_nxt;
      dropped_r      <= dropped_nxt;
      fwd_r          <= fwd_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    fwd_data_r <= fwd_data_nxt;
    tx_byte_r  <= tx_byte_nxt;
    level_r    <= level_nxt;
    ovf_r      <= ovf_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_byte     = tx_byte_r;
  assign out_ch.queue_level = level_r;
  assign out_ch.overflow    = ovf_r;

  // The fill count never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_LVL)
    else $error("queue fill count above depth");

  // An XOFF and an XON are never pending together.
  a_flow_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stop_pend_r && go_pend_r))
    else $error("XOFF and XON pending together");

  // An escape only goes out for a byte still in the queue.
  a_esc_queued: assert property (@(posedge clk) disable iff (!rst_n)
    esc_sent_r |-> (fill_r != '0))
    else $error("escape sent with empty queue");

  // A send always leaves the line busy until the next line-ready event.
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && send && state_nxt == ST_IDLE) |=> !line_free_r)
    else $error("line still free after a send");

endmodule

>>> design/stsq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> bench/stsq_line_check.sv
// Watches both channels of the serial transmit stuffing queue, predicts the line bytes
// and compares them with what the block hands out. Needs stsq_pkg and stsq_if.
module stsq_line_check #(
  parameter int QUEUE_DEPTH = 256,
  parameter int LVL_W       = 9
) (
  input  logic clk,
  input  logic rst_n,
  stsq_in_if   in_ch,
  stsq_out_if  out_ch,
  output int   fail_count,
  output int   due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import stsq_pkg::*;

  typedef struct packed {
    logic [7:0]       tx_byte;
    logic [LVL_W-1:0] queue_level;
    logic             overflow;
  } line_result_t;

  line_result_t line_due[$];

  // Shadow of the block's state.
  logic [7:0] ring [QUEUE_DEPTH];
  int         head;
  int         fill;
  logic       line_free;
  logic       peer_stopped;
  logic       stop_sent;
  logic       stop_pending;
  logic       go_pending;
  logic       escape_sent;

  function automatic logic is_special(input logic [7:0] b);
    return (b == BYTE_ESC) || (b == BYTE_XON) || (b == BYTE_XOFF);
  endfunction

  task automatic clear_line_state();
    head         = 0;
    fill         = 0;
    line_free    = 1'b1;
    peer_stopped = 1'b0;
    stop_sent    = 1'b0;
    stop_pending = 1'b0;
    go_pending   = 1'b0;
    escape_sent  = 1'b0;
  endtask

  // Applies one event word and queues the line byte or drop report it causes.
  task automatic step_line_model(input logic [2:0] req, input logic [7:0] data,
                                 input logic stop);
    logic         dropped;
    logic         sent;
    logic [7:0]   tx;
    logic [7:0]   head_byte;
    line_result_t r;
    dropped = 1'b0;
    sent    = 1'b0;
    tx      = BYTE_ESC;
    case (req)
      REQ_ENQUEUE: begin
        if (fill >= QUEUE_DEPTH) begin
          dropped = 1'b1;
        end else begin
          ring[(head + fill) % QUEUE_DEPTH] = data;
          fill++;
        end
      end
      REQ_LINE_READY: line_free = 1'b1;
      REQ_XOFF:       if (!stop_sent) stop_pending = 1'b1;
      REQ_XON:        if (stop_sent) go_pending = 1'b1;
      REQ_PEER_FLOW:  peer_stopped = stop;
      default: ;
    endcase

    // Flow bytes go out even when the peer has stopped us.
    if (line_free && (stop_pending || go_pending || !peer_stopped)) begin
      if (stop_pending) begin
        tx           = BYTE_XOFF;
        stop_sent    = 1'b1;
        stop_pending = 1'b0;
        sent         = 1'b1;
      end else if (go_pending) begin
        tx         = BYTE_XON;
        stop_sent  = 1'b0;
        go_pending = 1'b0;
        sent       = 1'b1;
      end else if (fill != 0) begin
        head_byte = ring[head];
        if (is_special(head_byte) && !escape_sent) begin
          tx          = BYTE_ESC;
          escape_sent = 1'b1;
        end else begin
          tx          = head_byte;
          escape_sent = 1'b0;
          head        = (head + 1) % QUEUE_DEPTH;
          fill--;
        end
        sent = 1'b1;
      end
      if (sent) line_free = 1'b0;
    end

    if (sent || dropped) begin
      r.tx_byte     = sent ? tx : 8'd0;
      r.queue_level = LVL_W'(fill);
      r.overflow    = dropped;
      line_due.push_back(r);
    end
  endtask

  task automatic check_line_word();
    line_result_t want;
    if (line_due.size() == 0) begin
      if (fail_count < 10)
        $display("[%0t] unexpected word: tx_byte=%0d queue_level=%0d overflow=%0b",
                 $realtime, out_ch.tx_byte, out_ch.queue_level, out_ch.overflow);
      fail_count++;
    end else begin
      want = line_due.pop_front();
      if (out_ch.tx_byte !== want.tx_byte || out_ch.queue_level !== want.queue_level ||
          out_ch.overflow !== want.overflow) begin
        if (fail_count < 10)
          $display("[%0t] mismatch: expected tx_byte=%0d queue_level=%0d overflow=%0b, %s",
                   $realtime, want.tx_byte, want.queue_level, want.overflow,
                   $sformatf("got tx_byte=%0d queue_level=%0d overflow=%0b",
                             out_ch.tx_byte, out_ch.queue_level, out_ch.overflow));
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line_state();
      line_due.delete();
    end else begin
      // A result is always registered after its event is taken, so checking
      // first and predicting second keeps the order straight.
      if (out_ch.valid && out_ch.ready) check_line_word();
      if (in_ch.valid && in_ch.ready)
        step_line_model(in_ch.req_type, in_ch.data_byte, in_ch.peer_stop);
    end
    due_count = line_due.size();
  end

endmodule

>>> bench/tb.sv
// Top of the serial transmit stuffing queue bench: clock, reset, event stimulus and verdict.
// Needs stsq_pkg, stsq_if, the block itself and stsq_line_check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsq_pkg::*;

  localparam int QUEUE_DEPTH    = 256;
  localparam int LVL_W          = 9;
  // Random event words after the directed part; each idling phase aims for a third of them.
  localparam int RANDOM_WORDS   = 1000;
  // Cycles in a row with no word moving on either channel before we give up. A correct
  // run only goes quiet during random idling, so this is generous.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles left to run once nothing more is expected, so a stray word can still show.
  localparam int TAIL_CYCLES    = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stsq_in_if                  in_ch ();
  stsq_out_if #(.LVL_W(LVL_W)) out_ch ();

  int fail_count;
  int due_count;
  int send_idle_pct = 28;
  int recv_idle_pct = 52;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  serial_tx_stuffing_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stsq_line_check #(.QUEUE_DEPTH(QUEUE_DEPTH), .LVL_W(LVL_W)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always #1 clk = ~clk;

  // The receiver side: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on a hung handshake. It only counts cycles in which nothing is accepted,
  // so a long but healthy run never trips it.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, quiet_cycles);
      $display("serial_tx_stuffing_queue verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Payload for an enqueue: the three bytes that need stuffing turn up often, since they
  // are the interesting ones, the rest is spread over the whole byte range.
  function automatic logic [7:0] pick_payload();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return BYTE_ESC;
    if (roll == 1) return BYTE_XON;
    if (roll == 2) return BYTE_XOFF;
    return 8'($urandom_range(255));
  endfunction

  // Offers one event word and returns at the falling edge after it has been taken.
  // The task is always entered at a falling edge. Valid is left high on return, so
  // back-to-back words need no second assignment in the same step.
  task automatic put_word(input logic [2:0] req, input logic [7:0] data, input logic stop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.data_byte <= data;
    in_ch.peer_stop <= stop;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // A stretch of mixed traffic. enq_pct and ready_pct weigh enqueues against line-ready
  // events, which sets whether the queue tends to fill or drain; what is left over goes
  // to flow requests, peer updates and the unused request codes. Fields that the request
  // does not use still carry random values.
  task automatic run_traffic(input int count, input int enq_pct, input int ready_pct);
    int         roll;
    int         pick;
    logic [2:0] req;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < enq_pct) begin
        req = REQ_ENQUEUE;
      end else if (roll < enq_pct + ready_pct) begin
        req = REQ_LINE_READY;
      end else begin
        pick = $urandom_range(9);
        if (pick < 3)      req = REQ_XOFF;
        else if (pick < 6) req = REQ_XON;
        else if (pick < 9) req = REQ_PEER_FLOW;
        else               req = 3'($urandom_range(REQ_RSVD_7, REQ_RSVD_5));
      end
      put_word(req, pick_payload(), 1'($urandom_range(1)));
    end
  endtask

  // Stops the peer and keeps enqueueing past the end of the ring, so that the queue
  // fills, every further byte is dropped with overflow, and the peer then lets it drain.
  task automatic fill_past_full();
    put_word(REQ_PEER_FLOW, 8'($urandom_range(255)), 1'b1);
    repeat (QUEUE_DEPTH + 6) put_word(REQ_ENQUEUE, pick_payload(), 1'($urandom_range(1)));
    put_word(REQ_PEER_FLOW, 8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    int phase;
    int phase_end;
    int seg_len;
    int bias;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_ENQUEUE;
    in_ch.data_byte = 8'd0;
    in_ch.peer_stop = 1'b0;
    out_ch.ready    = 1'b0;

    // Reset is held from the start and released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. It walks the line through a plain byte, an escaped byte with an
    // XOFF slipped in between the escape and its data, redundant flow requests, an XON
    // sent while the peer holds us, line ready on a free line, the unused request codes
    // and both stuffed flow values back to back.
    put_word(REQ_ENQUEUE,    8'h41,    1'b0);
    put_word(REQ_ENQUEUE,    BYTE_ESC, 1'b1);
    put_word(REQ_LINE_READY, 8'hff,    1'b0);
    put_word(REQ_XOFF,       8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b1);
    put_word(REQ_XOFF,       8'hff,    1'b1);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_ENQUEUE,    8'hff,    1'b0);
    put_word(REQ_PEER_FLOW,  8'h00,    1'b1);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_XON,        8'h80,    1'b0);
    put_word(REQ_XON,        8'h01,    1'b1);
    put_word(REQ_RSVD_5,     8'h7f,    1'b1);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_PEER_FLOW,  8'hff,    1'b0);
    put_word(REQ_ENQUEUE,    BYTE_XON, 1'b0);
    put_word(REQ_ENQUEUE,    BYTE_XOFF, 1'b1);
    put_word(REQ_RSVD_7,     8'haa,    1'b0);
    put_word(REQ_LINE_READY, 8'h55,    1'b1);
    put_word(REQ_RSVD_6,     8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);
    put_word(REQ_LINE_READY, 8'h00,    1'b0);

    // Random part in three idling phases: sender idles less than the receiver, then the
    // other way round, then neither idles. The first phase opens with a fill past full
    // so that the ring wraps and overflow is seen with and without a byte going out.
    phase_end = words_sent;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end += RANDOM_WORDS / 3;
      if (phase == 0) fill_past_full();
      while (words_sent < phase_end) begin
        seg_len = $urandom_range(60, 20);
        bias    = $urandom_range(9);
        // Some stretches lean to filling, some to draining, half are balanced; right
        // after a fill the queue stays near full and keeps overflowing for a while.
        if (bias < 3)      run_traffic(seg_len, 55, 30);
        else if (bias < 8) run_traffic(seg_len, 40, 40);
        else               run_traffic(seg_len, 20, 65);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every predicted word, then run on through the tail for strays.
    while (due_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && due_count == 0)
      $display("serial_tx_stuffing_queue verification clean");
    else
      $display("serial_tx_stuffing_queue verification failed");
    $finish;
  end

endmodule

>>> sim.f
design/stsq_pkg.sv
design/stsq_if.sv
design/stsq_ram.sv
design/serial_tx_stuffing_queue.sv
bench/stsq_line_check.sv
bench/tb.sv
